### design/stm_pkg.sv
// Package for the seek target motion step unit: payload structs, widths,
// the CORDIC arctangent table and the register map. No dependencies.
package stm_pkg;

    localparam int CordicIterationsDef = 16;
    localparam int FractionBitsDef     = 8;
    localparam int AtanTableLen        = 24;
    localparam int PosW                = 24;
    localparam logic [15:0] SpeedReset = 16'd3200;
    localparam logic [1:0]  RegSpeedAddr = 2'd0;

    typedef struct packed {
        logic signed [15:0] target_x;
        logic signed [15:0] target_y;
        logic        [15:0] elapsed;
    } stm_in_t;

    typedef struct packed {
        logic signed [23:0] new_x;
        logic signed [23:0] new_y;
        logic        [15:0] heading;
        logic               moved;
    } stm_out_t;

    function automatic logic [31:0] atan_turn(input logic [4:0] idx);
        logic [31:0] v;
        begin
            case (idx)
                5'd0:  v = 32'h20000000;
                5'd1:  v = 32'h12E4051E;
                5'd2:  v = 32'h09FB385B;
                5'd3:  v = 32'h051111D4;
                5'd4:  v = 32'h028B0D43;
                5'd5:  v = 32'h0145D7E1;
                5'd6:  v = 32'h00A2F61E;
                5'd7:  v = 32'h00517C55;
                5'd8:  v = 32'h0028BE53;
                5'd9:  v = 32'h00145F2F;
                5'd10: v = 32'h000A2F98;
                5'd11: v = 32'h000517CC;
                5'd12: v = 32'h00028BE6;
                5'd13: v = 32'h000145F3;
                5'd14: v = 32'h0000A2FA;
                5'd15: v = 32'h0000517D;
                5'd16: v = 32'h000028BE;
                5'd17: v = 32'h0000145F;
                5'd18: v = 32'h00000A30;
                5'd19: v = 32'h00000518;
                5'd20: v = 32'h0000028C;
                5'd21: v = 32'h00000146;
                5'd22: v = 32'h000000A3;
                5'd23: v = 32'h00000051;
                default: v = 32'h0;
            endcase
            return v;
        end
    endfunction

endpackage

### design/stm_cordic.sv
// Iterative CORDIC vectoring unit: one micro-rotation per cycle.
// Depends on stm_pkg for the arctangent table.
module stm_cordic #(
    parameter int CORDIC_ITERATIONS = stm_pkg::CordicIterationsDef
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [25:0] dx,
    input  logic signed [25:0] dy,
    output logic               done,
    output logic        [31:0] angle
);
    import stm_pkg::*;

    localparam int Iters = (CORDIC_ITERATIONS < AtanTableLen) ?
                           CORDIC_ITERATIONS : AtanTableLen;

    // Inputs scaled by 2^16; gain 1.65 needs two more bits.
    logic signed [44:0] x_reg, x_next, y_reg, y_next;
    logic [31:0] acc_reg, acc_next;
    logic [4:0]  i_reg, i_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic signed [44:0] xs, ys, x0, y0;

    always_comb begin
        x0 = 45'(dx) <<< 16;
        y0 = 45'(dy) <<< 16;
        xs = x_reg >>> i_reg;
        ys = y_reg >>> i_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        acc_next  = acc_reg;
        i_next    = i_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            busy_next = 1'b1;
            i_next    = 5'd0;
            if (dx < 0) begin
                x_next   = -x0;
                y_next   = -y0;
                acc_next = 32'h80000000;
            end else begin
                x_next   = x0;
                y_next   = y0;
                acc_next = 32'h0;
            end
        end else if (busy_reg) begin
            if (y_reg > 0) begin
                x_next   = x_reg + ys;
                y_next   = y_reg - xs;
                acc_next = acc_reg + atan_turn(i_reg);
            end else begin
                x_next   = x_reg - ys;
                y_next   = y_reg + xs;
                acc_next = acc_reg - atan_turn(i_reg);
            end
            i_next = i_reg + 5'd1;
            if (i_reg == 5'(Iters - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        x_reg   <= x_next;
        y_reg   <= y_next;
        acc_reg <= acc_next;
        i_reg   <= i_next;
    end

    assign done  = done_reg;
    assign angle = acc_reg;
endmodule

### design/seek_target_motion_step_unit.sv
// Top level of the seek target motion step unit: sequencer, shared
// shift/subtract unit for square root and division, position state, APB port.
// Depends on stm_pkg and stm_cordic.
//
//  Channel | Direction | Handshake       | Payload
//  s_      | in        | s_valid/s_ready | stm_in_t  (target_x, target_y, elapsed)
//  m_      | out       | m_valid/m_ready | stm_out_t (new_x, new_y, heading, moved)
//  apb     | in/out    | psel/penable    | speed register at address 0
//
// A request that stays within 0.1 pixel goes from the stay test straight to
// the output register. A move forms the offset, squared length and stay test,
// takes the square root and then divides and applies each axis in turn on the
// shared one-bit-per-cycle shift/subtract unit, and then hands off; CORDIC runs
// beside the square root. Reset clears position and facing and sets speed to
// 3200. s_ready is high in idle; a finished request waits while m_ready stalls.
module seek_target_motion_step_unit #(
    parameter int CORDIC_ITERATIONS = stm_pkg::CordicIterationsDef,
    parameter int FRACTION_BITS     = stm_pkg::FractionBitsDef
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  stm_pkg::stm_in_t s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output stm_pkg::stm_out_t m_data,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [1:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import stm_pkg::*;

    localparam int Shift = 20 - FRACTION_BITS;
    // 100 * sum exceeds 2^(2F) exactly when sum exceeds this integer.
    localparam logic [51:0] StayLimit = 52'((64'd1 << (2 * FRACTION_BITS)) / 64'd100);
    localparam logic [63:0] Half = 64'd1 << (Shift - 1);

    typedef enum logic [10:0] {
        ST_IDLE  = 11'b000_0000_0001,
        ST_DIFF  = 11'b000_0000_0010,
        ST_TEST  = 11'b000_0000_0100,
        ST_CHECK = 11'b000_0000_1000,
        ST_SQRT  = 11'b000_0001_0000,
        ST_DIVX  = 11'b000_0010_0000,
        ST_APPX  = 11'b000_0100_0000,
        ST_DIVY  = 11'b000_1000_0000,
        ST_APPY  = 11'b001_0000_0000,
        ST_WAIT  = 11'b010_0000_0000,
        ST_OUT   = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic [15:0] speed_reg;
    logic signed [23:0] px_reg, py_reg;
    logic [15:0] facing_reg;
    stm_in_t in_reg;
    logic signed [25:0] dx_reg, dy_reg;
    logic [51:0] sum_reg;
    logic [31:0] num_reg;
    // Shared unit: remainder, quotient/root, operand and counter.
    logic [57:0] rem_reg;
    logic [63:0] quo_reg;
    logic [63:0] dvd_reg;
    logic [25:0] len_reg;
    logic [6:0]  cnt_reg;
    logic        ang_done_reg;
    logic        moved_reg;
    stm_out_t    out_reg;
    logic        out_valid_reg;

    logic signed [39:0] tx_full, ty_full;
    logic signed [25:0] tx, ty;
    logic [25:0] mag_x, mag_y;
    logic [57:0] sq_trial, dv_trial, sq_rem_sh, dv_rem_sh;
    logic        sq_fit, dv_fit;
    logic [25:0] root_last;
    logic        take_in, take_out, go_move, out_free;
    logic        cordic_start, cordic_done;
    logic [31:0] cordic_angle;
    logic [31:0] acc_fix;
    logic [63:0] q_rnd, q_step;
    logic        axis_neg;
    logic signed [23:0] axis_pos;
    logic signed [25:0] step_s, step_pos;
    logic signed [23:0] sat_pos;

    stm_cordic #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cordic_start),
        .dx      (dx_reg),
        .dy      (dy_reg),
        .done    (cordic_done),
        .angle   (cordic_angle)
    );

    assign pready  = 1'b1;
    assign prdata  = (paddr == RegSpeedAddr) ? {16'h0, speed_reg} : 32'h0;
    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    assign take_in  = s_valid && s_ready;
    assign take_out = m_valid && m_ready;
    assign out_free = !out_valid_reg || m_ready;

    // Targets are scaled to fixed point and pinned to the position range.
    assign tx_full = 40'(in_reg.target_x) <<< FRACTION_BITS;
    assign ty_full = 40'(in_reg.target_y) <<< FRACTION_BITS;
    always_comb begin
        if (tx_full > 40'sd8388607) tx = 26'sd8388607;
        else if (tx_full < -40'sd8388608) tx = -26'sd8388608;
        else tx = tx_full[25:0];
        if (ty_full > 40'sd8388607) ty = 26'sd8388607;
        else if (ty_full < -40'sd8388608) ty = -26'sd8388608;
        else ty = ty_full[25:0];
    end

    assign mag_x = dx_reg[25] ? 26'(-dx_reg) : dx_reg;
    assign mag_y = dy_reg[25] ? 26'(-dy_reg) : dy_reg;
    assign go_move = sum_reg > StayLimit;
    assign cordic_start = (state_reg == ST_CHECK) && go_move;

    // Square root: two bits of the radicand enter each cycle.
    assign sq_rem_sh = {rem_reg[55:0], sum_reg[51:50]};
    assign sq_trial  = {quo_reg[55:0], 2'b01};
    assign sq_fit    = sq_rem_sh >= sq_trial;
    assign root_last = {quo_reg[24:0], sq_fit};
    // Division: one dividend bit enters each cycle.
    assign dv_rem_sh = {rem_reg[56:0], dvd_reg[63]};
    assign dv_trial  = 58'(len_reg);
    assign dv_fit    = dv_rem_sh >= dv_trial;
    assign acc_fix = cordic_angle + 32'h80000000 + 32'h8000;

    // Rounded step from the finished quotient, applied to one axis.
    assign q_rnd  = quo_reg + Half;
    assign q_step = q_rnd >> Shift;
    always_comb begin
        if (state_reg == ST_APPX) begin
            axis_neg = dx_reg[25];
            axis_pos = px_reg;
        end else begin
            axis_neg = dy_reg[25];
            axis_pos = py_reg;
        end
        step_s   = axis_neg ? -$signed(q_step[25:0]) : $signed(q_step[25:0]);
        step_pos = 26'(axis_pos) + step_s;
        if (step_pos > 26'sd8388607) sat_pos = 24'sh7FFFFF;
        else if (step_pos < -26'sd8388608) sat_pos = 24'sh800000;
        else sat_pos = step_pos[23:0];
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (take_in) state_next = ST_DIFF;
            ST_DIFF:  state_next = ST_TEST;
            ST_TEST:  state_next = ST_CHECK;
            ST_CHECK: state_next = go_move ? ST_SQRT : ST_OUT;
            ST_SQRT:  if (cnt_reg == 7'd25) state_next = ST_DIVX;
            ST_DIVX:  if (cnt_reg == 7'd63) state_next = ST_APPX;
            ST_APPX:  state_next = ST_DIVY;
            ST_DIVY:  if (cnt_reg == 7'd63) state_next = ST_APPY;
            ST_APPY:  state_next = ST_WAIT;
            ST_WAIT:  if (ang_done_reg) state_next = ST_OUT;
            ST_OUT:   if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            speed_reg     <= SpeedReset;
            px_reg        <= '0;
            py_reg        <= '0;
            facing_reg    <= '0;
            out_valid_reg <= 1'b0;
            ang_done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (psel && penable && pwrite && paddr == RegSpeedAddr) begin
                speed_reg <= pwdata[15:0];
            end
            if (state_reg == ST_IDLE) begin
                ang_done_reg <= 1'b0;
            end else if (cordic_done) begin
                ang_done_reg <= 1'b1;
                facing_reg   <= acc_fix[31:16];
            end
            if (state_reg == ST_APPX) px_reg <= sat_pos;
            if (state_reg == ST_APPY) py_reg <= sat_pos;
            if (state_reg == ST_OUT && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (take_out) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take_in) in_reg <= s_data;
        if (state_reg == ST_OUT && out_free) begin
            out_reg.new_x   <= px_reg;
            out_reg.new_y   <= py_reg;
            out_reg.heading <= facing_reg;
            out_reg.moved   <= moved_reg;
        end
        unique case (state_reg) inside
            ST_DIFF: begin
                dx_reg  <= tx - 26'(px_reg);
                dy_reg  <= ty - 26'(py_reg);
                num_reg <= 32'(speed_reg) * 32'(in_reg.elapsed);
            end
            ST_TEST: begin
                sum_reg <= 52'(mag_x) * 52'(mag_x) + 52'(mag_y) * 52'(mag_y);
            end
            ST_CHECK: begin
                moved_reg <= go_move;
                rem_reg   <= '0;
                quo_reg   <= '0;
                cnt_reg   <= '0;
            end
            ST_SQRT: begin
                sum_reg <= {sum_reg[49:0], 2'b00};
                if (cnt_reg == 7'd25) begin
                    len_reg <= root_last;
                    dvd_reg <= 64'(num_reg) * 64'(mag_x);
                    rem_reg <= '0;
                    quo_reg <= '0;
                    cnt_reg <= '0;
                end else begin
                    rem_reg <= sq_fit ? sq_rem_sh - sq_trial : sq_rem_sh;
                    quo_reg <= {quo_reg[62:0], sq_fit};
                    cnt_reg <= cnt_reg + 7'd1;
                end
            end
            ST_DIVX, ST_DIVY: begin
                dvd_reg <= {dvd_reg[62:0], 1'b0};
                rem_reg <= dv_fit ? dv_rem_sh - dv_trial : dv_rem_sh;
                quo_reg <= {quo_reg[62:0], dv_fit};
                cnt_reg <= cnt_reg + 7'd1;
            end
            ST_APPX: begin
                dvd_reg <= 64'(num_reg) * 64'(mag_y);
                rem_reg <= '0;
                quo_reg <= '0;
                cnt_reg <= '0;
            end
            default: begin
            end
        endcase
    end
endmodule
